// ===== rtl/quadratic_probe_hash_table_unit_macros.svh =====
// assertion macros used by the hash table datapath module
// no dependencies; modules that use them must have clk and rst in scope
`ifndef QUADRATIC_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// condition that holds at every edge out of reset
`define QPH_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("hash table check failed");

// condition that implies another in the next cycle
`define QPH_NEXT(name, cond, result) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
    else $error("hash table sequence check failed");

`endif

// ===== rtl/qph_pkg.sv =====
// shared types and codes for the quadratic probe hash table unit
// no dependencies
package qph_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;

  localparam logic [1:0] MARK_EMPTY    = 2'd0;
  localparam logic [1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [1:0] MARK_DELETED  = 2'd2;

  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_DUPLICATE   = 3'd1;
  localparam logic [2:0] ST_PROBE_LIMIT = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_REMOVED     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd5;
  localparam logic [2:0] ST_FOUND       = 3'd6;

  localparam logic [10:0] SIZE_RESET = 11'd1021;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic div_step;
    logic rd;
    logic chk;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic full;
    logic finish;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/qph_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/qph_ctrl.sv =====
// request sequencer: clearing pass, division, probe walk, result hand-off
// depends on qph_pkg
module qph_ctrl
  import qph_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = sts.full ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk    = 1'b1;
        state_next = sts.finish ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== rtl/qph_dp.sv =====
// datapath: size register, home slot division, probe arithmetic, slot store, result
// depends on qph_pkg, qph_ram and the assertion macros header
`include "quadratic_probe_hash_table_unit_macros.svh"
module qph_dp
  import qph_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_valid,
  input  logic [10:0] cfg_data,
  input  logic [1:0]  in_kind,
  input  logic [30:0] in_key,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int SW     = $clog2(TABLE_DEPTH + 1);
  localparam int W1     = SW + 1;
  localparam int KW     = (KEY_BITS < 31) ? KEY_BITS : 31;
  localparam int KSTEPS = (KW + 3) / 4;
  localparam int KP     = KSTEPS * 4;
  localparam int CW     = (KSTEPS > 1) ? $clog2(KSTEPS) : 1;

  logic [10:0]   tsz;
  logic [SW-1:0] size;
  logic [1:0]    kind;
  logic [KW-1:0] key;
  logic [KP-1:0] div_sh, div_sh_next;
  logic [SW-1:0] rem_q, rem_next;
  logic [CW-1:0] div_cnt;
  logic [AW-1:0] p, p_next;
  logic [AW-1:0] d, d_next;
  logic [SW-1:0] i;
  logic [SW-1:0] count;
  logic [2:0]    res_status;
  logic [AW-1:0] res_slot;
  logic          full;
  logic [AW-1:0] clr_addr;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [KW+1:0] ram_wdata, ram_rdata;
  logic [1:0]    rd_mark;
  logic [KW-1:0] rd_key;

  logic          hit, limit, do_write;
  logic [2:0]    chk_status;
  logic [1:0]    wr_mark;
  logic [W1-1:0] r, t;

  always_ff @(posedge clk) begin
    if (rst) begin
      tsz <= SIZE_RESET;
    end else if (cfg_valid) begin
      tsz <= cfg_data;
    end
  end

  always_comb begin
    if (32'(tsz) > 32'(TABLE_DEPTH)) begin
      size = SW'(TABLE_DEPTH);
    end else if (tsz == 11'd0) begin
      size = SW'(1);
    end else begin
      size = SW'(tsz);
    end
  end

  // four restoring steps a cycle for key modulo size
  always_comb begin
    r           = {1'b0, rem_q};
    div_sh_next = div_sh;
    for (int j = 0; j < 4; j++) begin
      r           = {r[SW-1:0], div_sh_next[KP-1]};
      div_sh_next = {div_sh_next[KP-2:0], 1'b0};
      if (r >= {1'b0, size}) begin
        r = r - {1'b0, size};
      end
    end
    rem_next = r[SW-1:0];
  end

  // next probe: p += d, d += 2, both reduced modulo size
  always_comb begin
    t = W1'(p) + W1'(d);
    if (t >= {1'b0, size}) begin
      t = t - {1'b0, size};
    end
    p_next = t[AW-1:0];
    t = W1'(d) + W1'(2);
    if (t >= {1'b0, size}) begin
      t = t - {1'b0, size};
    end
    if (t >= {1'b0, size}) begin
      t = t - {1'b0, size};
    end
    d_next = t[AW-1:0];
  end

  assign rd_mark = ram_rdata[KW+1:KW];
  assign rd_key  = ram_rdata[KW-1:0];
  assign limit   = (W1'(i) + W1'(1)) == {1'b0, size};

  always_comb begin
    hit        = 1'b0;
    do_write   = 1'b0;
    wr_mark    = MARK_OCCUPIED;
    chk_status = (kind == KIND_INSERT) ? ST_PROBE_LIMIT : ST_NOT_FOUND;
    if (kind == KIND_INSERT) begin
      if (rd_mark != MARK_OCCUPIED) begin
        hit        = 1'b1;
        do_write   = 1'b1;
        chk_status = ST_INSERTED;
      end else if (rd_key == key) begin
        hit        = 1'b1;
        chk_status = ST_DUPLICATE;
      end
    end else begin
      if (rd_mark == MARK_EMPTY) begin
        hit        = 1'b1;
        chk_status = ST_NOT_FOUND;
      end else if (rd_mark == MARK_OCCUPIED && rd_key == key) begin
        hit = 1'b1;
        if (kind == KIND_REMOVE) begin
          do_write   = 1'b1;
          wr_mark    = MARK_DELETED;
          chk_status = ST_REMOVED;
        end else begin
          chk_status = ST_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.chk && do_write) begin
        if (kind == KIND_INSERT) begin
          count <= count + SW'(1);
        end else if (count != '0) begin
          count <= count - SW'(1);
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind       <= in_kind;
      key        <= in_key[KW-1:0];
      div_sh     <= KP'(in_key[KW-1:0]);
      rem_q      <= '0;
      div_cnt    <= '0;
      res_slot   <= '0;
      full       <= (in_kind == KIND_INSERT) &&
                    ((SW+3)'(count) * (SW+3)'(5) >= (SW+3)'(size) * (SW+3)'(4));
      res_status <= (in_kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end
    if (cmd.div_step) begin
      div_sh  <= div_sh_next;
      rem_q   <= rem_next;
      div_cnt <= div_cnt + CW'(1);
      p       <= rem_next[AW-1:0];
      d       <= (size == SW'(1)) ? '0 : AW'(1);
      i       <= '0;
    end
    if (cmd.chk) begin
      p <= p_next;
      d <= d_next;
      i <= i + SW'(1);
      if (hit || limit) begin
        res_status <= chk_status;
      end
      if (hit && (chk_status == ST_INSERTED || chk_status == ST_REMOVED ||
                  chk_status == ST_FOUND)) begin
        res_slot <= p;
      end
    end
    if (cmd.out_load) begin
      m_tdata <= {11'(count), 10'(res_slot), res_status};
    end
  end

  assign ram_we    = cmd.clr || (cmd.chk && do_write);
  assign ram_addr  = cmd.clr ? clr_addr : p;
  assign ram_wdata = cmd.clr ? {MARK_EMPTY, KW'(0)} : {wr_mark, key};

  qph_ram #(
    .WIDTH (KW + 2),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign sts.clr_last = clr_addr == AW'(TABLE_DEPTH - 1);
  assign sts.div_last = div_cnt == CW'(KSTEPS - 1);
  assign sts.full     = full;
  assign sts.finish   = hit || limit;
  assign sts.out_free = !m_tvalid || m_tready;

  `QPH_ALWAYS(a_one_op, $onehot0({cmd.clr, cmd.div_step, cmd.rd, cmd.chk, cmd.load}))
  `QPH_ALWAYS(a_no_overwrite, !(cmd.out_load && m_tvalid && !m_tready))
  `QPH_ALWAYS(a_count_bound, 32'(count) <= 32'(TABLE_DEPTH))
  `QPH_NEXT(a_read_then_check, cmd.rd, cmd.chk)

endmodule

// ===== rtl/quadratic_probe_hash_table_unit.sv =====
// channel  dir  signals                          content
// s        in   s_tvalid s_tready s_tdata s_tuser key, kind
// m        out  m_tvalid m_tready m_tdata        status, slot, item_count
// cfg      in   cfg_valid cfg_ready cfg_data     table_size
// after reset a clearing pass marks every slot empty; no items taken meanwhile
// one item at a time: accept, key division, a read and a check per probe, then result
// probe count depends on occupancy; a full insert skips the probe walk
// results wait in an output register; a stalled m side holds the next result
// top level of the quadratic probe hash table; depends on qph_pkg, qph_ctrl, qph_dp
module quadratic_probe_hash_table_unit
  import qph_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[30:0], zero pad
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[2:0], slot[12:3], item_count[23:13]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qph_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_kind   (s_tuser),
    .in_key    (s_tdata[30:0]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for quadratic_probe_hash_table_unit
// holds its own model of the probed key store; depends on qph_pkg and the unit's rtl
`timescale 1ns / 1ps

module testbench;
  import qph_pkg::*;

  localparam int DEPTH = 1024;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] key;
  } request_t;

  typedef struct packed {
    logic [10:0] item_count;
    logic [9:0]  slot;
    logic [2:0]  status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  quadratic_probe_hash_table_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // model state
  logic [30:0] model_key [DEPTH];
  logic [1:0]  model_mark [DEPTH];
  int          model_count = 0;
  logic [10:0] model_size = SIZE_RESET;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  bit       offer_busy = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_left = 0;
  bit       hold_request = 0;
  bit       hold_done = 0;
  bit       quiet = 0;
  int       errors = 0;
  int       idle_cycles = 0;

  function automatic answer_t lookup_and_update(request_t req);
    answer_t a;
    longint sz;
    int p;
    sz = (model_size == 0) ? 1 : ((model_size > DEPTH) ? DEPTH : model_size);
    a.status = ST_NOT_FOUND;
    a.slot = '0;
    if (req.kind == KIND_INSERT) begin
      if (longint'(model_count) * 5 >= sz * 4) begin
        a.status = ST_FULL;
      end else begin
        a.status = ST_PROBE_LIMIT;
        for (longint i = 0; i < sz; i++) begin
          p = int'(((req.key % sz) + i * i) % sz);
          if (model_mark[p] != MARK_OCCUPIED) begin
            model_key[p] = req.key;
            model_mark[p] = MARK_OCCUPIED;
            model_count++;
            a.status = ST_INSERTED;
            a.slot = p[9:0];
            break;
          end
          if (model_key[p] == req.key) begin
            a.status = ST_DUPLICATE;
            break;
          end
        end
      end
    end else begin
      for (longint i = 0; i < sz; i++) begin
        p = int'(((req.key % sz) + i * i) % sz);
        if (model_mark[p] == MARK_EMPTY) break;
        if (model_mark[p] == MARK_OCCUPIED && model_key[p] == req.key) begin
          a.slot = p[9:0];
          if (req.kind == KIND_REMOVE) begin
            model_mark[p] = MARK_DELETED;
            if (model_count > 0) model_count--;
            a.status = ST_REMOVED;
          end else begin
            a.status = ST_FOUND;
          end
          break;
        end
      end
    end
    a.item_count = model_count[10:0];
    return a;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst && !offer_busy) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        s_tdata <= {1'b0, pending_requests[0].key};
        s_tuser <= pending_requests[0].kind;
        s_tvalid <= 1'b1;
        offer_busy <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_answers.push_back(lookup_and_update(pending_requests.pop_front()));
      offer_busy <= 1'b0;
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (hold_request && !hold_done && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= (hold_left == 1);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      recv_gap <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
          errors++;
        end
        if (got.item_count !== want.item_count) begin
          $display("%0t: item_count expected %0d actual %0d", $time, want.item_count,
                   got.item_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_size(input logic [10:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    model_size = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || offer_busy || expected_answers.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic push(input logic [1:0] kind, input logic [30:0] key);
    request_t r;
    r.kind = kind;
    r.key = key;
    pending_requests.push_back(r);
  endtask

  initial begin
    int sizes[11];
    int eff, pick;
    logic [30:0] k;
    sizes = '{13, 7, 61, 3, 127, 0, 31, 1021, 2047, 11, 1024};
    for (int n = 0; n < DEPTH; n++) begin
      model_mark[n] = MARK_EMPTY;
      model_key[n] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: collisions, probe limit, deleted reuse, full table
    write_size(11'd7);
    push(KIND_INSERT, 31'd1);
    push(KIND_INSERT, 31'd2);
    push(KIND_INSERT, 31'd4);
    push(KIND_INSERT, 31'd14);
    push(KIND_INSERT, 31'd14);
    push(KIND_INSERT, 31'd21);
    push(KIND_SEARCH, 31'd21);
    push(KIND_SEARCH, 31'd14);
    push(KIND_SPARE, 31'd4);
    push(KIND_REMOVE, 31'd2);
    push(KIND_REMOVE, 31'd2);
    push(KIND_SEARCH, 31'd21);
    push(KIND_INSERT, 31'd21);
    push(KIND_INSERT, 31'h7FFF_FFFF);
    push(KIND_INSERT, 31'd0);
    push(KIND_INSERT, 31'd3);
    push(KIND_INSERT, 31'd14);
    push(KIND_SEARCH, 31'h7FFF_FFFF);
    push(KIND_REMOVE, 31'h7FFF_FFFF);
    push(KIND_REMOVE, 31'd5);
    wait_drained();

    for (int ph = 0; ph < 11; ph++) begin
      write_size(sizes[ph][10:0]);
      eff = (sizes[ph] == 0) ? 1 : ((sizes[ph] > DEPTH) ? DEPTH : sizes[ph]);
      if (ph == 2) hold_request = 1'b1;
      if (ph == 10) quiet = 1'b1;
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(0, 9) == 0) k = 31'($urandom);
        else k = 31'($urandom_range(0, 3 * eff));
        pick = $urandom_range(0, 9);
        if (pick < 4) push(KIND_INSERT, k);
        else if (pick < 7) push(KIND_REMOVE, k);
        else if (pick < 9) push(KIND_SEARCH, k);
        else push(KIND_SPARE, k);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
